// ----- hw/rtl/fung_exponential_energy_eval_defines.svh -----
// Assertion macros shared by the Fung energy evaluator RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef FUNG_EXPONENTIAL_ENERGY_EVAL_DEFINES_SVH
`define FUNG_EXPONENTIAL_ENERGY_EVAL_DEFINES_SVH

// same-cycle implication
`define FUNG_ASSERT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("fung: same-cycle check failed");

// next-cycle implication
`define FUNG_ASSERT_NXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("fung: next-cycle check failed");

`endif

// ----- hw/rtl/fung_pkg.sv -----
// Package for the Fung energy evaluator: constants, beat types, exp2 table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fung_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam logic [19:0] ONE_F     = 20'(64'd1 << FRAC_BITS);
  localparam logic [30:0] OUT_MAX   = 31'h7FFF_FFFF;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  // exponent limit and Q2.30 to Q.F alignment
  localparam logic [6:0]  N_LIMIT   = 7'(62 - FRAC_BITS);
  localparam logic [6:0]  N_BASE    = 7'(30 - FRAC_BITS);
  localparam logic [23:0] REG_RESET = 24'(64'd1 << FRAC_BITS);

  // register index codes
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  // results that do not pass through the divider
  typedef struct packed {
    logic        huge;
    logic        dsat;
    logic [31:0] d1;
    logic [30:0] d2;
  } side_t;

  // front end to divider
  typedef struct packed {
    logic        valid;
    logic [85:0] num;
    side_t       side;
  } front_t;

  // divider to output stage
  typedef struct packed {
    logic        valid;
    logic [30:0] quot;
    logic        esat;
    side_t       side;
  } div_t;

  typedef logic [31:0] exp_tab_t [0:EXP_TABLE_DEPTH];

  // 2^(i/DEPTH) in Q2.30 from a 15-term Taylor sum, made non-decreasing
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      z    = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * z) >> 30) / 64'(k);
        sum  = sum + term;
      end
      tab[i] = sum[31:0];
    end
    tab[0]               = Q30_ONE[31:0];
    tab[EXP_TABLE_DEPTH] = 32'(2 * Q30_ONE);
    for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
      if (tab[i] < tab[i-1]) begin
        tab[i] = tab[i-1];
      end
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ----- hw/rtl/fung_exponential_energy_eval.sv -----
// Top level of the Fung exponential strain energy evaluator.
// Depends on fung_pkg, fung_front and fung_div.
//
//   channel   dir  handshake                       payload
//   config    in   psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//   stretch   in   stretch_valid / stretch_stall   stretch
//   result    out  result_valid / result_stall     energy, first_derivative,
//                                                  second_derivative, overflow
//
// One item per cycle unless the output stalls; depth 9 front stages, 32 divider stages,
// output register. The 31-stage restoring divider for the energy sets depth.
// Reset clears all valid bits and sets alpha and beta to 1.0.
// A stalled result freezes the whole pipeline; stretch_stall is raised only
// while the output register is full and stalled.
`timescale 1ns / 1ps
`include "fung_exponential_energy_eval_defines.svh"

module fung_exponential_energy_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               stretch_valid,
  output logic               stretch_stall,
  input  logic [19:0]        stretch,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [30:0]        energy,
  output logic signed [31:0] first_derivative,
  output logic [30:0]        second_derivative,
  output logic               overflow
);

  logic [23:0]      alpha;
  logic [23:0]      beta;
  logic [23:0]      a_eff;
  logic [23:0]      b_eff;
  logic             adv;
  fung_pkg::front_t front;
  fung_pkg::div_t   div_res;

  // config registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fung_pkg::REG_BETA) ? {8'b0, beta} : {8'b0, alpha};

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= fung_pkg::REG_RESET;
      beta  <= fung_pkg::REG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        fung_pkg::REG_ALPHA: alpha <= pwdata[23:0];
        fung_pkg::REG_BETA:  beta  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // zero acts as one LSB
  assign a_eff = (alpha == '0) ? 24'd1 : alpha;
  assign b_eff = (beta == '0) ? 24'd1 : beta;

  // pipeline moves whenever the output register can take a beat
  assign adv           = !result_valid || !result_stall;
  assign stretch_stall = !adv;

  fung_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (stretch_valid),
    .stretch  (stretch),
    .a_eff    (a_eff),
    .b_eff    (b_eff),
    .front    (front)
  );

  fung_div u_div (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .front  (front),
    .b_eff  (b_eff),
    .result (div_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= div_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      energy            <= (div_res.side.huge || div_res.esat) ? fung_pkg::OUT_MAX
                                                               : div_res.quot;
      first_derivative  <= $signed(div_res.side.d1);
      second_derivative <= div_res.side.d2;
      overflow          <= div_res.side.huge || div_res.side.dsat || div_res.esat;
    end
  end

  `FUNG_ASSERT_NXT(a_rst_clear, clk, 1'b0, rst, !result_valid && !div_res.valid)

endmodule

// ----- hw/rtl/fung_front.sv -----
// Front pipeline: stretch to exponential, derivative products, energy numerator.
// Depends on fung_pkg; feeds fung_div.
`timescale 1ns / 1ps
`include "fung_exponential_energy_eval_defines.svh"

module fung_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [19:0]         stretch,
  input  logic [23:0]         a_eff,
  input  logic [23:0]         b_eff,
  output fung_pkg::front_t    front
);

  logic [9:1] vld;

  // stage registers
  logic        s1_neg;
  logic [19:0] s1_ax;
  logic [23:0] s1_x2;

  logic        s2_neg, s2_axnz, s2_tbig;
  logic [21:0] s2_t;
  logic [22:0] s2_bx2;
  logic [43:0] s2_p1;

  logic        s3_neg, s3_axnz, s3_tbig;
  logic [22:0] s3_u;
  logic [43:0] s3_p1;
  logic [47:0] s3_p2;

  logic        s4_neg, s4_axnz, s4_big;
  logic [31:0] s4_t0, s4_diff;
  logic [7:0]  s4_f8;
  logic [6:0]  s4_n;
  logic [43:0] s4_p1;
  logic [47:0] s4_p2;

  logic        s5_neg, s5_axnz, s5_big;
  logic [31:0] s5_m;
  logic [6:0]  s5_n;
  logic [43:0] s5_p1;
  logic [47:0] s5_p2;

  logic        s6_neg, s6_axnz, s6_big;
  logic [62:0] s6_ef;
  logic [43:0] s6_p1;
  logic [47:0] s6_p2;

  logic        s7_neg, s7_axnz, s7_big;
  logic [61:0] s7_em1;
  logic [53:0] s7_a_ll, s7_a_hl;
  logic [52:0] s7_a_lh, s7_a_hh;
  logic [55:0] s7_b_ll, s7_b_hl;
  logic [54:0] s7_b_lh, s7_b_hh;

  logic         s8_neg, s8_axnz, s8_big;
  logic [54:0]  s8_e0, s8_e1;
  logic [106:0] s8_r1;
  logic [110:0] s8_r2;

  logic [85:0]     num_q;
  fung_pkg::side_t side_q;

  // combinational next values
  logic        neg_next;
  logic [19:0] ax_next;
  logic [39:0] sq_next;
  logic [47:0] bprod_next;
  logic [52:0] uprod_next;
  logic [23:0] c2_next;
  logic [8:0]  idx_next;
  logic [39:0] ip_next;
  logic [62:0] ef_next;
  logic [61:0] em1_next;
  logic [31:0] lim_next, mag_next;
  logic        sat1_next, sat2_next;
  fung_pkg::side_t side_next;

  // stage 1: |x| and x^2
  assign neg_next = stretch < fung_pkg::ONE_F;
  assign ax_next  = neg_next ? fung_pkg::ONE_F - stretch : stretch - fung_pkg::ONE_F;
  assign sq_next  = 40'(ax_next) * 40'(ax_next);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg <= neg_next;
      s1_ax  <= ax_next;
      s1_x2  <= sq_next[39:16];
    end
  end

  // stage 2: beta * x^2, alpha * |x|
  assign bprod_next = 48'(b_eff) * 48'(s1_x2);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_neg  <= s1_neg;
      s2_axnz <= s1_ax != '0;
      s2_tbig <= |bprod_next[47:39];
      s2_t    <= bprod_next[38:17];
      s2_bx2  <= bprod_next[38:16];
      s2_p1   <= 44'(a_eff) * 44'(s1_ax);
    end
  end

  // stage 3: t * log2(e), alpha * (1 + beta*x^2)
  assign uprod_next = 53'(s2_t) * 53'(fung_pkg::LOG2E_Q30);
  assign c2_next    = 24'(fung_pkg::ONE_F) + 24'(s2_bx2);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_neg  <= s2_neg;
      s3_axnz <= s2_axnz;
      s3_tbig <= s2_tbig;
      s3_u    <= uprod_next[52:30];
      s3_p1   <= s2_p1;
      s3_p2   <= 48'(a_eff) * 48'(c2_next);
    end
  end

  // stage 4: table lookup of both interpolation points
  assign idx_next = {1'b0, s3_u[15:8]} + 9'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_neg  <= s3_neg;
      s4_axnz <= s3_axnz;
      s4_big  <= s3_tbig || (s3_u[22:16] >= fung_pkg::N_LIMIT);
      s4_t0   <= fung_pkg::EXP_TAB[{1'b0, s3_u[15:8]}];
      s4_diff <= fung_pkg::EXP_TAB[idx_next] - fung_pkg::EXP_TAB[{1'b0, s3_u[15:8]}];
      s4_f8   <= s3_u[7:0];
      s4_n    <= s3_u[22:16];
      s4_p1   <= s3_p1;
      s4_p2   <= s3_p2;
    end
  end

  // stage 5: linear interpolation
  assign ip_next = 40'(s4_diff) * 40'(s4_f8);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_neg  <= s4_neg;
      s5_axnz <= s4_axnz;
      s5_big  <= s4_big;
      s5_m    <= s4_t0 + ip_next[39:8];
      s5_n    <= s4_n;
      s5_p1   <= s4_p1;
      s5_p2   <= s4_p2;
    end
  end

  // stage 6: scale mantissa by 2^n into Q.F
  always_comb begin
    if (s5_n >= fung_pkg::N_BASE) begin
      ef_next = 63'(s5_m) << 6'(s5_n - fung_pkg::N_BASE);
    end else begin
      ef_next = 63'(s5_m) >> 6'(fung_pkg::N_BASE - s5_n);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_neg  <= s5_neg;
      s6_axnz <= s5_axnz;
      s6_big  <= s5_big;
      s6_ef   <= ef_next;
      s6_p1   <= s5_p1;
      s6_p2   <= s5_p2;
    end
  end

  // stage 7: e - 1 and partial products of both derivatives
  assign em1_next = 62'(s6_ef - 63'(fung_pkg::ONE_F));

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_neg  <= s6_neg;
      s7_axnz <= s6_axnz;
      s7_big  <= s6_big;
      s7_em1  <= em1_next;
      s7_a_ll <= 54'(s6_p1[21:0]) * 54'(s6_ef[31:0]);
      s7_a_lh <= 53'(s6_p1[21:0]) * 53'(s6_ef[62:32]);
      s7_a_hl <= 54'(s6_p1[43:22]) * 54'(s6_ef[31:0]);
      s7_a_hh <= 53'(s6_p1[43:22]) * 53'(s6_ef[62:32]);
      s7_b_ll <= 56'(s6_p2[23:0]) * 56'(s6_ef[31:0]);
      s7_b_lh <= 55'(s6_p2[23:0]) * 55'(s6_ef[62:32]);
      s7_b_hl <= 56'(s6_p2[47:24]) * 56'(s6_ef[31:0]);
      s7_b_hh <= 55'(s6_p2[47:24]) * 55'(s6_ef[62:32]);
    end
  end

  // stage 8: energy partials, derivative product sums
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_neg  <= s7_neg;
      s8_axnz <= s7_axnz;
      s8_big  <= s7_big;
      s8_e0   <= 55'(a_eff) * 55'(s7_em1[30:0]);
      s8_e1   <= 55'(a_eff) * 55'(s7_em1[61:31]);
      s8_r1   <= 107'(s7_a_ll) + (107'(s7_a_lh) << 32) + (107'(s7_a_hl) << 22)
               + (107'(s7_a_hh) << 54);
      s8_r2   <= 111'(s7_b_ll) + (111'(s7_b_lh) << 32) + (111'(s7_b_hl) << 24)
               + (111'(s7_b_hh) << 56);
    end
  end

  // stage 9: energy numerator, derivative saturation and sign
  always_comb begin
    lim_next  = s8_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat1_next = (|s8_r1[106:65]) || (s8_r1[64:33] > lim_next);
    mag_next  = sat1_next ? lim_next : s8_r1[64:33];
    sat2_next = |s8_r2[110:64];
    side_next.huge = s8_big;
    if (s8_big) begin
      side_next.dsat = 1'b1;
      side_next.d1   = s8_neg ? 32'h8000_0000 : (s8_axnz ? 32'h7FFF_FFFF : 32'h0);
      side_next.d2   = fung_pkg::OUT_MAX;
    end else begin
      side_next.dsat = sat1_next || sat2_next;
      side_next.d1   = s8_neg ? (32'h0 - mag_next) : mag_next;
      side_next.d2   = sat2_next ? fung_pkg::OUT_MAX : s8_r2[63:33];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_q  <= (86'(s8_e1) << 31) + 86'(s8_e0);
      side_q <= side_next;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[8:1], in_valid};
    end
  end

  assign front = {vld[9], num_q, side_q};

  `FUNG_ASSERT_NXT(a_front_hold, clk, rst, !adv, $stable(vld))

endmodule

// ----- hw/rtl/fung_div.sv -----
// Pipelined restoring divider: energy = floor(num / (2*beta)), one quotient bit a stage.
// Depends on fung_pkg; fed by fung_front.
`timescale 1ns / 1ps
`include "fung_exponential_energy_eval_defines.svh"

module fung_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  fung_pkg::front_t  front,
  input  logic [23:0]       b_eff,
  output fung_pkg::div_t    result
);

  logic [24:0]       den;
  logic [31:0]       vld;
  logic [55:0]       rem  [0:31];
  logic [30:0]       quot [0:31];
  logic              esat [0:31];
  fung_pkg::side_t   side [0:31];

  assign den = {b_eff, 1'b0};

  // stage 0: quotient must fit 31 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      esat[0] <= (|front.num[85:56]) || (front.num[55:0] >= {den, 31'b0});
      rem[0]  <= front.num[55:0];
      quot[0] <= '0;
      side[0] <= front.side;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= 31; j++) begin : g_stage
    localparam int K = 31 - j;
    logic [55:0] dsh;
    logic        ge;
    assign dsh = 56'(den) << K;
    assign ge  = rem[j-1] >= dsh;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j]  <= ge ? rem[j-1] - dsh : rem[j-1];
        quot[j] <= quot[j-1] | (ge ? (31'd1 << K) : 31'd0);
        esat[j] <= esat[j-1];
        side[j] <= side[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[30:0], front.valid};
    end
  end

  assign result.valid = vld[31];
  assign result.quot  = quot[31];
  assign result.esat  = esat[31];
  assign result.side  = side[31];

  `FUNG_ASSERT_IMP(a_div_rem, clk, rst, vld[31] && !esat[31], rem[31] < 56'(den))
  `FUNG_ASSERT_NXT(a_div_hold, clk, rst, !adv, $stable(vld))

endmodule

// ----- test/fung_exponential_energy_eval_tb.sv -----
// Self-checking testbench for the Fung exponential strain energy evaluator.
// Holds a bit-exact predictor of the block; depends on fung_pkg and the DUT.
`timescale 1ns / 1ps

module fung_exponential_energy_eval_tb;

  localparam logic [2:0] ADDR_ALPHA = {fung_pkg::REG_ALPHA, 2'b00};
  localparam logic [2:0] ADDR_BETA  = {fung_pkg::REG_BETA, 2'b00};
  localparam logic [63:0] MAX_OUT   = 64'h7FFF_FFFF;
  localparam logic [63:0] UNITY     = 64'd1 << fung_pkg::FRAC_BITS;
  localparam logic [63:0] MASK_FRAC = UNITY - 1;

  typedef struct packed {
    logic [30:0] energy;
    logic [31:0] d1;
    logic [30:0] d2;
    logic        ovf;
  } fung_out_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               stretch_valid;
  logic               stretch_stall;
  logic [19:0]        stretch;
  logic               result_valid;
  logic               result_stall;
  logic [30:0]        energy;
  logic signed [31:0] first_derivative;
  logic [30:0]        second_derivative;
  logic               overflow;

  // mirrored registers and exp2 table
  logic [23:0] alpha_q, beta_q;
  logic [63:0] exp2_rom [0:fung_pkg::EXP_TABLE_DEPTH];

  fung_out_t pending_q[$];
  int        n_sent, n_checked, n_sat, n_bad;
  int        stall_mode;
  int        stall_left;

  fung_exponential_energy_eval u_dut (.*);

  always #4 clk = ~clk;

  // 2^(i/DEPTH) in Q2.30 via 15-term series of exp(i*ln2/DEPTH)
  task automatic load_exp2_rom();
    logic [63:0] z, term, acc;
    for (int i = 0; i <= fung_pkg::EXP_TABLE_DEPTH; i++) begin
      z    = (64'(i) * 64'd744261118) / fung_pkg::EXP_TABLE_DEPTH;
      term = 64'd1 << 30;
      acc  = term;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * z) >> 30) / 64'(k);
        acc  = acc + term;
      end
      exp2_rom[i] = acc;
    end
    exp2_rom[0]                         = 64'd1 << 30;
    exp2_rom[fung_pkg::EXP_TABLE_DEPTH] = 64'd1 << 31;
    for (int i = 1; i <= fung_pkg::EXP_TABLE_DEPTH; i++)
      if (exp2_rom[i] < exp2_rom[i-1]) exp2_rom[i] = exp2_rom[i-1];
  endtask

  // floor(x*y / 2^(2F+1)) clipped to lim
  function automatic logic [63:0] scale_clip(input logic [63:0] x, input logic [63:0] y,
                                             input logic [63:0] lim, inout logic sat);
    logic [127:0] prod;
    prod = ({64'd0, x} * {64'd0, y}) >> (2 * fung_pkg::FRAC_BITS + 1);
    if (prod > {64'd0, lim}) begin
      sat = 1'b1;
      return lim;
    end
    return prod[63:0];
  endfunction

  function automatic fung_out_t fung_eval(input logic [19:0] r);
    fung_out_t   res;
    logic [63:0] a, b, ax, x2, bprod, t, bx2, u, n, p, idx, s, m, ef, em1, twob, q, rr;
    logic [63:0] en, mag, d2v;
    logic        neg, sat;
    a     = (alpha_q == 0) ? 64'd1 : 64'(alpha_q);
    b     = (beta_q == 0) ? 64'd1 : 64'(beta_q);
    neg   = 64'(r) < UNITY;
    ax    = neg ? UNITY - 64'(r) : 64'(r) - UNITY;
    x2    = (ax * ax) >> fung_pkg::FRAC_BITS;
    bprod = b * x2;
    t     = bprod >> (fung_pkg::FRAC_BITS + 1);
    bx2   = bprod >> fung_pkg::FRAC_BITS;
    sat   = 1'b0;
    u     = (t * 64'd1549082005) >> 30;
    n     = u >> fung_pkg::FRAC_BITS;
    // huge exponent: everything pinned
    if (t >= (64'd1 << (fung_pkg::FRAC_BITS + 6)) ||
        n >= 64'(62 - fung_pkg::FRAC_BITS)) begin
      res.energy = MAX_OUT[30:0];
      res.d1     = neg ? 32'h8000_0000 : (ax != 0 ? 32'h7FFF_FFFF : 32'd0);
      res.d2     = MAX_OUT[30:0];
      res.ovf    = 1'b1;
      return res;
    end
    p   = (u & MASK_FRAC) * fung_pkg::EXP_TABLE_DEPTH;
    idx = (p >> fung_pkg::FRAC_BITS) % fung_pkg::EXP_TABLE_DEPTH;
    s   = p & MASK_FRAC;
    m   = exp2_rom[idx] + (((exp2_rom[idx+1] - exp2_rom[idx]) * s) >> fung_pkg::FRAC_BITS);
    if (n >= 64'(30 - fung_pkg::FRAC_BITS)) ef = m << (n - 64'(30 - fung_pkg::FRAC_BITS));
    else ef = m >> (64'(30 - fung_pkg::FRAC_BITS) - n);
    em1  = ef - UNITY;
    twob = 2 * b;
    q    = em1 / twob;
    rr   = em1 % twob;
    if (q > MAX_OUT) begin
      en  = MAX_OUT;
      sat = 1'b1;
    end else begin
      en = a * q + (a * rr) / twob;
      if (en > MAX_OUT) begin
        en  = MAX_OUT;
        sat = 1'b1;
      end
    end
    mag        = scale_clip(a * ax, ef, neg ? MAX_OUT + 1 : MAX_OUT, sat);
    d2v        = scale_clip(a * (UNITY + bx2), ef, MAX_OUT, sat);
    res.energy = en[30:0];
    res.d1     = neg ? 32'(0 - mag) : mag[31:0];
    res.d2     = d2v[30:0];
    res.ovf    = sat;
    return res;
  endfunction

  // predict every accepted stretch beat
  always @(posedge clk) begin
    if (!rst && stretch_valid && !stretch_stall) begin
      pending_q.push_back(fung_eval(stretch));
      n_sent++;
    end
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    fung_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (want.ovf) n_sat++;
        if (want.energy !== energy || want.d1 !== first_derivative ||
            want.d2 !== second_derivative || want.ovf !== overflow) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp W=%h W'=%h W''=%h ov=%b  got W=%h W'=%h W''=%h ov=%b",
                     want.energy, want.d1, want.d2, want.ovf,
                     energy, first_derivative, second_derivative, overflow);
        end
      end
    end
  end

  // receiver stall: off, or random bursts mostly short
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (stall_mode != 0 && $urandom_range(0, 99) < 30) begin
      stall_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_ALPHA) alpha_q = val[23:0];
    else beta_q = val[23:0];
  endtask

  task automatic set_params(input logic [31:0] a, input logic [31:0] b);
    reg_write(ADDR_ALPHA, a);
    reg_write(ADDR_BETA, b);
  endtask

  // one stretch beat after an optional gap; valid stays high into the next call
  task automatic send_stretch(input logic [19:0] r, input bit gaps);
    int gap;
    gap = 0;
    if (gaps && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      stretch_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stretch_valid <= 1'b1;
    stretch       <= r;
    do @(posedge clk); while (stretch_stall);
  endtask

  // wait until all results are in, then let the pipeline settle
  task automatic drain();
    stretch_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // stretch near 1.0 most of the time, anywhere otherwise
  function automatic logic [19:0] pick_stretch();
    int span;
    if ($urandom_range(0, 99) < 60) begin
      span = 1 << $urandom_range(4, 19);
      return 20'(int'(UNITY) + $urandom_range(0, 2 * span) - span);
    end
    return 20'($urandom());
  endfunction

  task automatic test_directed();
    logic [19:0] pts [14] = '{20'h00000, 20'h0FFFF, 20'h10000, 20'h10001, 20'h18000,
                              20'h20000, 20'h08000, 20'h40000, 20'h8FFFF, 20'h90000,
                              20'hC5000, 20'hC5037, 20'hFFFFF, 20'h7FFFF};
    stall_mode = 0;
    foreach (pts[i]) send_stretch(pts[i], 1'b0);
    drain();
  endtask

  // registers written as zero behave as one LSB
  task automatic test_zero_regs();
    set_params(32'd0, 32'd0);
    send_stretch(20'h10000, 1'b0);
    send_stretch(20'hFFFFF, 1'b0);
    send_stretch(20'h00000, 1'b0);
    send_stretch(20'h12345, 1'b0);
    drain();
  endtask

  task automatic test_extremes();
    set_params(32'hFFFF_FFFF, 32'h00FF_FFFF);
    send_stretch(20'h10000, 1'b1);
    send_stretch(20'h10001, 1'b1);
    send_stretch(20'h0FFFF, 1'b1);
    send_stretch(20'h10100, 1'b1);
    drain();
    set_params(32'd1, 32'd1);
    send_stretch(20'h10000, 1'b1);
    send_stretch(20'hFFFFF, 1'b1);
    send_stretch(20'h00000, 1'b1);
    drain();
  endtask

  task automatic test_random(input int items);
    int per;
    per = items / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_params(32'h0001_0000, 32'h0001_0000);
        1: set_params($urandom(), $urandom_range(1, 32'h0004_0000));
        default: set_params($urandom(), $urandom());
      endcase
      stall_mode = (ph != 0);
      for (int i = 0; i < per; i++) send_stretch(pick_stretch(), ph != 0);
      drain();
    end
  endtask

  initial begin
    #5_000_000;
    $display("fung_exponential_energy_eval verification failed");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    stretch_valid = 1'b0;
    stretch       = '0;
    result_stall  = 1'b0;
    stall_mode    = 0;
    stall_left    = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_sat         = 0;
    n_bad         = 0;
    alpha_q       = fung_pkg::REG_RESET;
    beta_q        = fung_pkg::REG_RESET;
    load_exp2_rom();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_zero_regs();
    test_extremes();
    test_random(480);

    $display("checked %0d of %0d stretch beats, %0d saturated, across 8 register settings",
             n_checked, n_sent, n_sat);
    if (n_bad == 0 && pending_q.size() == 0) begin
      $display("fung_exponential_energy_eval verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", n_bad, pending_q.size());
      $display("fung_exponential_energy_eval verification failed");
    end
    $finish;
  end

endmodule
